FILE: hw/rtl/sha1_pkg.sv
// ----------------------------------------------------------------------------
// sha1_pkg
// Types and constants shared by the SHA-1 stream hasher controller, datapath
// and top level.
// ----------------------------------------------------------------------------
package sha1_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PAD,
    ST_LEN,
    ST_ROUND,
    ST_FINISH,
    ST_EMIT
  } state_t;

  // what follows the compression that is under way
  typedef enum logic [1:0] {
    TAIL_MSG,
    TAIL_PAD,
    TAIL_FINAL
  } tail_t;

  typedef struct packed {
    logic capture;
    logic load_chunk;
    logic pad;
    logic len_block;
    logic start;
    logic round;
    logic finish;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic chunk_full;
    logic rem_zero;
    logic eom;
    logic pad_fits;
    logic round_last;
    logic out_free;
  } status_t;

  localparam logic [31:0] IV0 = 32'h6745_2301;
  localparam logic [31:0] IV1 = 32'hefcd_ab89;
  localparam logic [31:0] IV2 = 32'h98ba_dcfe;
  localparam logic [31:0] IV3 = 32'h1032_5476;
  localparam logic [31:0] IV4 = 32'hc3d2_e1f0;

  localparam logic [31:0] K0 = 32'h5a82_7999;
  localparam logic [31:0] K1 = 32'h6ed9_eba1;
  localparam logic [31:0] K2 = 32'h8f1b_bcdc;
  localparam logic [31:0] K3 = 32'hca62_c1d6;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;
  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [2:0] MAX_BYTES  = 3'd4;

endpackage

FILE: hw/rtl/sha1_ctrl.sv
// ----------------------------------------------------------------------------
// sha1_ctrl
// Sequencer: byte loading, padding, length block, 80 rounds, digest hand-off.
// ----------------------------------------------------------------------------
module sha1_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  sha1_pkg::status_t sts,
  output sha1_pkg::cmd_t    cmd,
  output logic              in_stall
);

  sha1_pkg::state_t state, state_next;
  sha1_pkg::tail_t  tail, tail_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha1_pkg::ST_IDLE;
      tail  <= sha1_pkg::TAIL_MSG;
    end else begin
      state <= state_next;
      tail  <= tail_next;
    end
  end

  always_comb begin
    state_next = state;
    tail_next  = tail;
    unique case (state)
      sha1_pkg::ST_IDLE: begin
        if (in_valid) state_next = sha1_pkg::ST_LOAD;
      end
      sha1_pkg::ST_LOAD: begin
        if (sts.chunk_full) begin
          state_next = sha1_pkg::ST_ROUND;
          tail_next  = sha1_pkg::TAIL_MSG;
        end else if (sts.eom) begin
          state_next = sha1_pkg::ST_PAD;
        end else begin
          state_next = sha1_pkg::ST_IDLE;
        end
      end
      sha1_pkg::ST_PAD: begin
        state_next = sha1_pkg::ST_ROUND;
        tail_next  = sts.pad_fits ? sha1_pkg::TAIL_FINAL : sha1_pkg::TAIL_PAD;
      end
      sha1_pkg::ST_LEN: begin
        state_next = sha1_pkg::ST_ROUND;
        tail_next  = sha1_pkg::TAIL_FINAL;
      end
      sha1_pkg::ST_ROUND: begin
        if (sts.round_last) state_next = sha1_pkg::ST_FINISH;
      end
      sha1_pkg::ST_FINISH: begin
        unique case (tail)
          sha1_pkg::TAIL_MSG: begin
            if (!sts.rem_zero)  state_next = sha1_pkg::ST_LOAD;
            else if (sts.eom)   state_next = sha1_pkg::ST_PAD;
            else                state_next = sha1_pkg::ST_IDLE;
          end
          sha1_pkg::TAIL_PAD:   state_next = sha1_pkg::ST_LEN;
          sha1_pkg::TAIL_FINAL: state_next = sha1_pkg::ST_EMIT;
          default:              state_next = sha1_pkg::ST_IDLE;
        endcase
      end
      sha1_pkg::ST_EMIT: begin
        if (sts.out_free) state_next = sha1_pkg::ST_IDLE;
      end
      default: state_next = sha1_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      sha1_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      sha1_pkg::ST_LOAD: begin
        cmd.load_chunk = 1'b1;
        cmd.start      = sts.chunk_full;
      end
      sha1_pkg::ST_PAD: begin
        cmd.pad   = 1'b1;
        cmd.start = 1'b1;
      end
      sha1_pkg::ST_LEN: begin
        cmd.len_block = 1'b1;
        cmd.start     = 1'b1;
      end
      sha1_pkg::ST_ROUND:  cmd.round  = 1'b1;
      sha1_pkg::ST_FINISH: cmd.finish = 1'b1;
      sha1_pkg::ST_EMIT:   cmd.emit   = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

FILE: hw/rtl/sha1_dpath.sv
// ----------------------------------------------------------------------------
// sha1_dpath
// Block buffer / message schedule, round registers, chaining value, bit
// length and the digest output register.
// ----------------------------------------------------------------------------
module sha1_dpath (
  input  logic              clk,
  input  logic              rst,
  input  sha1_pkg::cmd_t    cmd,
  output sha1_pkg::status_t sts,
  input  logic [31:0]       msg_word,
  input  logic [2:0]        byte_count,
  input  logic              end_of_message,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       digest_h0,
  output logic [31:0]       digest_h1,
  output logic [31:0]       digest_h2,
  output logic [31:0]       digest_h3,
  output logic [31:0]       digest_h4
);

  // w[0] is the word of the current round; bytes sit big-endian in words
  logic [31:0] w [16];
  logic [31:0] w_next [16];
  logic [31:0] chain [5];
  logic [31:0] a, b, c, d, e;
  logic [6:0]  rcnt;
  logic [31:0] held;
  logic [2:0]  rem;
  logic        eom;
  logic [5:0]  fill;
  logic [63:0] bits;

  logic [6:0]  room;
  logic        chunk_full;
  logic [2:0]  n;
  logic [5:0]  off;
  logic [31:0] f, k, t, sched;

  assign room       = 7'd64 - {1'b0, fill};
  assign chunk_full = ({4'd0, rem} >= room);
  assign n          = chunk_full ? room[2:0] : rem;

  assign sts.chunk_full = chunk_full;
  assign sts.rem_zero   = (rem == 3'd0);
  assign sts.eom        = eom;
  assign sts.pad_fits   = (fill < sha1_pkg::LEN_OFFSET);
  assign sts.round_last = (rcnt == sha1_pkg::LAST_ROUND);
  assign sts.out_free   = !out_valid || !out_stall;

  // round function
  always_comb begin
    if (rcnt < 7'd20) begin
      f = (b & c) | (~b & d);
      k = sha1_pkg::K0;
    end else if (rcnt < 7'd40) begin
      f = b ^ c ^ d;
      k = sha1_pkg::K1;
    end else if (rcnt < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = sha1_pkg::K2;
    end else begin
      f = b ^ c ^ d;
      k = sha1_pkg::K3;
    end
    t     = {a[26:0], a[31:27]} + f + e + w[0] + k;
    sched = w[13] ^ w[8] ^ w[2] ^ w[0];
  end

  // block buffer: byte lanes, padding, length words and schedule shift
  always_comb begin
    off = '0;
    for (int i = 0; i < 16; i++) w_next[i] = w[i];
    priority if (cmd.load_chunk) begin
      for (int s = 0; s < 64; s++) begin
        off = 6'(s) - fill;
        if (off < {3'd0, n})
          w_next[s / 4][8 * (3 - (s % 4)) +: 8] = held[8 * (3 - off[1:0]) +: 8];
      end
    end else if (cmd.pad) begin
      for (int s = 0; s < 64; s++) begin
        if (6'(s) == fill)
          w_next[s / 4][8 * (3 - (s % 4)) +: 8] = sha1_pkg::PAD_BYTE;
        else if (6'(s) > fill)
          w_next[s / 4][8 * (3 - (s % 4)) +: 8] = 8'd0;
      end
      if (sts.pad_fits) begin
        w_next[14] = bits[63:32];
        w_next[15] = bits[31:0];
      end
    end else if (cmd.len_block) begin
      for (int i = 0; i < 14; i++) w_next[i] = 32'd0;
      w_next[14] = bits[63:32];
      w_next[15] = bits[31:0];
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) w_next[i] = w[i + 1];
      w_next[15] = {sched[30:0], sched[31]};
    end else begin
      for (int i = 0; i < 16; i++) w_next[i] = w[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 16; i++) w[i] <= w_next[i];
  end

  // control-side registers
  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0]  <= sha1_pkg::IV0;
      chain[1]  <= sha1_pkg::IV1;
      chain[2]  <= sha1_pkg::IV2;
      chain[3]  <= sha1_pkg::IV3;
      chain[4]  <= sha1_pkg::IV4;
      fill      <= '0;
      bits      <= '0;
      rem       <= '0;
      eom       <= 1'b0;
      rcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.capture) begin
        rem <= (byte_count > sha1_pkg::MAX_BYTES) ? sha1_pkg::MAX_BYTES : byte_count;
        eom <= end_of_message;
      end
      if (cmd.load_chunk) begin
        rem  <= rem - n;
        fill <= fill + {3'd0, n};
        bits <= bits + {58'd0, n, 3'd0};
      end
      if (cmd.pad) fill <= '0;
      if (cmd.start) rcnt <= '0;
      else if (cmd.round) rcnt <= rcnt + 7'd1;
      if (cmd.finish) begin
        chain[0] <= chain[0] + a;
        chain[1] <= chain[1] + b;
        chain[2] <= chain[2] + c;
        chain[3] <= chain[3] + d;
        chain[4] <= chain[4] + e;
      end
      if (cmd.emit) begin
        chain[0] <= sha1_pkg::IV0;
        chain[1] <= sha1_pkg::IV1;
        chain[2] <= sha1_pkg::IV2;
        chain[3] <= sha1_pkg::IV3;
        chain[4] <= sha1_pkg::IV4;
        fill     <= '0;
        bits     <= '0;
        eom      <= 1'b0;
      end
      if (cmd.emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) held <= msg_word;
    else if (cmd.load_chunk) held <= held << {n, 3'd0};
    if (cmd.start) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
      e <= chain[4];
    end else if (cmd.round) begin
      e <= d;
      d <= c;
      c <= {b[1:0], b[31:2]};
      b <= a;
      a <= t;
    end
    if (cmd.emit) begin
      digest_h0 <= chain[0];
      digest_h1 <= chain[1];
      digest_h2 <= chain[2];
      digest_h3 <= chain[3];
      digest_h4 <= chain[4];
    end
  end

endmodule

FILE: hw/rtl/sha1_stream_hasher_core.sv
// ----------------------------------------------------------------------------
// sha1_stream_hasher_core
// Sequence: an item that does not complete a block is accepted, then loaded.
// Completing a 64-byte block adds the 80 rounds and the chain update.
// End of message: pad step, rounds and chain update per final block (one or
// two), length-block setup before the second one, emit once output is free.
// Rounds run one per cycle; a new item is taken only when the block is idle.
// Reset: synchronous, active high; chaining value returns to the SHA-1 IV,
// fill and length clear, output register empties.
// ----------------------------------------------------------------------------
// Streaming SHA-1 hasher: bytes arrive big-endian in 32-bit words with a
// valid-byte count (values above four act as four). A 16-word buffer doubles
// as the rolling message schedule. The controller walks load, pad, length
// and round phases; the datapath holds all storage. The digest sits in an
// output register so the next message may start while it waits to be taken.
// ----------------------------------------------------------------------------
module sha1_stream_hasher_core (
  input  logic        clk,
  input  logic        rst,
  // input item channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] msg_word,
  input  logic [2:0]  byte_count,
  input  logic        end_of_message,
  // digest item channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_h0,
  output logic [31:0] digest_h1,
  output logic [31:0] digest_h2,
  output logic [31:0] digest_h3,
  output logic [31:0] digest_h4
);

  sha1_pkg::cmd_t    cmd;
  sha1_pkg::status_t sts;

  // sequencer: takes an item only when idle
  sha1_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  // storage and arithmetic
  sha1_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .msg_word       (msg_word),
    .byte_count     (byte_count),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .digest_h0      (digest_h0),
    .digest_h1      (digest_h1),
    .digest_h2      (digest_h2),
    .digest_h3      (digest_h3),
    .digest_h4      (digest_h4)
  );

endmodule

FILE: hw/rtl/sha1_checker.sv
// ----------------------------------------------------------------------------
// sha1_checker
// Port-level checks for the SHA-1 stream hasher, bound to the top level.
// ----------------------------------------------------------------------------
module sha1_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] digest_h0,
  input logic [31:0] digest_h1,
  input logic [31:0] digest_h2,
  input logic [31:0] digest_h3,
  input logic [31:0] digest_h4
);

  // held digest stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(digest_h0) && $stable(digest_h1)
      && $stable(digest_h2) && $stable(digest_h3) && $stable(digest_h4))
    else $error("digest changed while stalled");

  // an accepted item always keeps the block busy for the load cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again without a load cycle");

  // a digest needs at least the round phase, so out_valid cannot rise straight after the load step
  a_no_quick_digest: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> ##1 !$rose(out_valid))
    else $error("digest appeared too early");

  // reset leaves the block ready and empty
  a_reset_state: assert property (@(posedge clk)
    rst |=> !in_stall && !out_valid)
    else $error("not idle after reset");

endmodule

bind sha1_stream_hasher_core sha1_checker u_sha1_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .digest_h0 (digest_h0),
  .digest_h1 (digest_h1),
  .digest_h2 (digest_h2),
  .digest_h3 (digest_h3),
  .digest_h4 (digest_h4)
);

FILE: tb/sv/tb_sha1_stream_hasher_core.sv
// ----------------------------------------------------------------------------
// tb_sha1_stream_hasher_core
// Self-checking bench for the streaming SHA-1 hasher. Message items go in
// through the valid/stall input channel. A local SHA-1 predictor models the
// byte packing, padding and block compression, and queues the expected
// digest for each end-of-message item. A checker compares every digest that
// leaves the output channel with the oldest queued one, word by word.
// ----------------------------------------------------------------------------
module tb_sha1_stream_hasher_core;

  // SHA-1 initial chaining words and round constants
  localparam logic [31:0] INIT_H0 = 32'h6745_2301;
  localparam logic [31:0] INIT_H1 = 32'hefcd_ab89;
  localparam logic [31:0] INIT_H2 = 32'h98ba_dcfe;
  localparam logic [31:0] INIT_H3 = 32'h1032_5476;
  localparam logic [31:0] INIT_H4 = 32'hc3d2_e1f0;
  localparam logic [31:0] RK_CH   = 32'h5a82_7999;  // rounds 0..19
  localparam logic [31:0] RK_PAR1 = 32'h6ed9_eba1;  // rounds 20..39
  localparam logic [31:0] RK_MAJ  = 32'h8f1b_bcdc;  // rounds 40..59
  localparam logic [31:0] RK_PAR2 = 32'hca62_c1d6;  // rounds 60..79
  localparam logic [7:0]  MARK_BYTE  = 8'h80;       // first padding byte
  localparam int          LEN_START  = 56;          // bit length goes at 56..63
  localparam int          BYTES_MAX  = 4;           // counts above this saturate

  localparam int IDLE_PCT       = 35;
  localparam int HOLDOFF_CYCLES = 1500;
  localparam int DRAIN_CYCLES   = 200;   // > two final blocks plus pad and emit
  localparam int RANDOM_ITEMS   = 1300;

  typedef struct packed {
    logic [31:0] h0;
    logic [31:0] h1;
    logic [31:0] h2;
    logic [31:0] h3;
    logic [31:0] h4;
  } digest_t;

  // block ports; every input known from time zero
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] msg_word = '0;
  logic [2:0]  byte_count = '0;
  logic        end_of_message = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] digest_h0;
  logic [31:0] digest_h1;
  logic [31:0] digest_h2;
  logic [31:0] digest_h3;
  logic [31:0] digest_h4;

  // predictor state: chaining value, partial block, fill and length
  logic [31:0] chain_words [5];
  logic [7:0]  block_bytes [64];
  int unsigned block_fill;
  logic [63:0] msg_len_bytes;

  digest_t     pending_digests [$];
  int          error_count = 0;
  int          items_sent = 0;
  int          idle_pct = IDLE_PCT;   // shared by sender and receiver
  int          holdoff_requests = 0;  // bumped by the test sequence only

  sha1_stream_hasher_core u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .msg_word       (msg_word),
    .byte_count     (byte_count),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .digest_h0      (digest_h0),
    .digest_h1      (digest_h1),
    .digest_h2      (digest_h2),
    .digest_h3      (digest_h3),
    .digest_h4      (digest_h4)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // SHA-1 predictor
  // --------------------------------------------------------------------------

  function automatic void restart_hash();
    chain_words[0] = INIT_H0;
    chain_words[1] = INIT_H1;
    chain_words[2] = INIT_H2;
    chain_words[3] = INIT_H3;
    chain_words[4] = INIT_H4;
    block_fill     = 0;
    msg_len_bytes  = '0;
  endfunction

  // 80 rounds over the full block; w[] is a rolling 16-entry schedule
  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, t, x;
    for (int i = 0; i < 16; i++) begin
      w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    end
    a = chain_words[0];
    b = chain_words[1];
    c = chain_words[2];
    d = chain_words[3];
    e = chain_words[4];
    for (int r = 0; r < 80; r++) begin
      if (r >= 16) begin
        x = w[(r-3) & 15] ^ w[(r-8) & 15] ^ w[(r-14) & 15] ^ w[r & 15];
        w[r & 15] = {x[30:0], x[31]};
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = RK_CH;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = RK_PAR1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = RK_MAJ;
      end else begin
        f = b ^ c ^ d;
        k = RK_PAR2;
      end
      t = {a[26:0], a[31:27]} + f + e + w[r & 15] + k;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain_words[0] += a;
    chain_words[1] += b;
    chain_words[2] += c;
    chain_words[3] += d;
    chain_words[4] += e;
  endfunction

  function automatic void append_byte(input logic [7:0] v);
    block_bytes[block_fill] = v;
    block_fill++;
    if (block_fill == 64) begin
      compress_block();
      block_fill = 0;
    end
  endfunction

  // Apply one accepted item; an end flag pads, queues the digest and restarts.
  function automatic void absorb_item(input logic [31:0] word, input logic [2:0] cnt,
                                      input logic eom);
    int          n;
    logic [63:0] bit_len;
    digest_t     dg;
    n = (cnt > BYTES_MAX) ? BYTES_MAX : cnt;
    for (int i = 0; i < n; i++) begin
      append_byte(word[31 - 8*i -: 8]);
      msg_len_bytes++;
    end
    if (eom) begin
      bit_len = msg_len_bytes << 3;   // wraps mod 2^64
      append_byte(MARK_BYTE);
      while (block_fill != LEN_START) append_byte(8'h00);
      for (int i = 0; i < 8; i++) append_byte(bit_len[63 - 8*i -: 8]);
      dg = '{chain_words[0], chain_words[1], chain_words[2], chain_words[3], chain_words[4]};
      pending_digests.push_back(dg);
      restart_hash();
    end
  endfunction

  // --------------------------------------------------------------------------
  // Output side: stall generator and digest checker
  // --------------------------------------------------------------------------

  // Random stalls at idle_pct; a hold-off request pins stall high for a
  // counted stretch so the block's output register fills and input backs up.
  initial begin : drive_out_stall
    int holdoff_served;
    holdoff_served = 0;
    forever begin
      @(posedge clk);
      if (holdoff_served != holdoff_requests) begin
        holdoff_served++;
        out_stall <= 1'b1;
        repeat (HOLDOFF_CYCLES - 1) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < idle_pct);
      end
    end
  end

  function automatic void check_word(input string name, input logic [31:0] exp_w,
                                     input logic [31:0] act_w);
    if (act_w !== exp_w) begin
      $error("%s expected %h actual %h", name, exp_w, act_w);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    digest_t dg;
    if (!rst && out_valid && !out_stall) begin
      if (pending_digests.size() == 0) begin
        $error("digest with none expected: %h %h %h %h %h",
               digest_h0, digest_h1, digest_h2, digest_h3, digest_h4);
        error_count++;
      end else begin
        dg = pending_digests.pop_front();
        check_word("digest_h0", dg.h0, digest_h0);
        check_word("digest_h1", dg.h1, digest_h1);
        check_word("digest_h2", dg.h2, digest_h2);
        check_word("digest_h3", dg.h3, digest_h3);
        check_word("digest_h4", dg.h4, digest_h4);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offer one item after a random idle gap (noise on the payload while idle),
  // hold it until accepted, then feed the predictor. Valid stays high so the
  // next call can follow back to back; end_input drops it.
  task automatic send_item(input logic [31:0] word, input logic [2:0] cnt, input logic eom);
    while ($urandom_range(99) < idle_pct) begin
      in_valid       <= 1'b0;
      msg_word       <= $urandom;
      byte_count     <= 3'($urandom);
      end_of_message <= 1'($urandom);
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    msg_word       <= word;
    byte_count     <= cnt;
    end_of_message <= eom;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_item(word, cnt, eom);
    items_sent++;
  endtask

  task automatic end_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // One message of len bytes, cut into items of random count (5..7 included,
  // acting as 4) and random words; the last item carries the end flag and
  // may hold zero bytes.
  task automatic send_message(input int len);
    int          left;
    int          eff;
    logic [2:0]  cnt;
    left = len;
    forever begin
      cnt = 3'($urandom_range(7));
      eff = (cnt > BYTES_MAX) ? BYTES_MAX : cnt;
      if (eff >= left) begin
        if (left == BYTES_MAX && $urandom_range(1))
          cnt = 3'($urandom_range(7, BYTES_MAX));
        else
          cnt = 3'(left);
        send_item($urandom, cnt, 1'b1);
        break;
      end
      send_item($urandom, cnt, 1'b0);
      left -= eff;
    end
  endtask

  function automatic int pick_length();
    int sel;
    sel = $urandom_range(99);
    if (sel < 15) return $urandom_range(53, 66);      // around the pad split
    else if (sel < 25) return $urandom_range(117, 130);
    else if (sel < 30) return $urandom_range(150, 300);
    else return $urandom_range(0, 52);
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // empty message, short message with junk in unused bytes, all-ones and
  // all-zeros words, and an end item with no bytes after real data
  task automatic test_short_messages();
    send_item(32'hdead_beef, 3'd0, 1'b1);
    send_item(32'h6162_63ff, 3'd3, 1'b1);
    send_item(32'hffff_ffff, 3'd4, 1'b0);
    send_item(32'h0000_0000, 3'd4, 1'b1);
    send_item(32'h1234_5678, 3'd2, 1'b0);
    send_item(32'hffff_ffff, 3'd0, 1'b1);
  endtask

  // counts 5, 6 and 7 must behave as 4
  task automatic test_count_saturation();
    send_item(32'h0102_0304, 3'd5, 1'b0);
    send_item(32'h0506_0708, 3'd6, 1'b0);
    send_item(32'h090a_0b0c, 3'd7, 1'b0);
    send_item(32'h0d0e_0f10, 3'd7, 1'b1);
  endtask

  // lengths that land the end just before, on and after the pad and block
  // boundaries (one or two final blocks)
  task automatic test_block_boundaries();
    int lens [15] = '{0, 1, 3, 4, 5, 54, 55, 56, 57, 63, 64, 65, 119, 120, 128};
    foreach (lens[i]) send_message(lens[i]);
  endtask

  task automatic test_random_stream();
    int target;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) send_message(pick_length());
  endtask

  // neither side idles: input offered every cycle, output never stalled
  task automatic test_back_to_back();
    int target;
    idle_pct = 0;
    target = items_sent + 200;
    while (items_sent < target) send_message(pick_length());
    idle_pct = IDLE_PCT;
  endtask

  // output held off while short messages keep coming, so the digest register
  // stays full and the block has to stall its input
  task automatic test_output_holdoff();
    holdoff_requests++;
    repeat (10) send_message($urandom_range(0, 8));
  endtask

  initial begin
    restart_hash();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_short_messages();
    test_count_saturation();
    test_block_boundaries();
    test_random_stream();
    test_back_to_back();
    test_output_holdoff();
    end_input();

    // every digest in, then let any late output show up
    while (pending_digests.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #24_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/sha1_pkg.sv
hw/rtl/sha1_ctrl.sv
hw/rtl/sha1_dpath.sv
hw/rtl/sha1_stream_hasher_core.sv
hw/rtl/sha1_checker.sv
tb/sv/tb_sha1_stream_hasher_core.sv
